### design/btsm_pkg.sv
// ----------------------------------------------------------------------------
// btsm_pkg
// shared widths, codes and parameter defaults of the byte trie signature matcher
// ----------------------------------------------------------------------------
package btsm_pkg;

  localparam int ALPHABET  = 256;
  localparam int BYTE_W    = 8;
  localparam int ID_W      = 6;
  localparam int STATUS_W  = 2;
  localparam int DEPTH_W   = 5;

  localparam logic [DEPTH_W-1:0] DEPTH_SAT = 5'd31;

  // parameter defaults
  localparam int NODE_COUNT_DEF  = 256;
  localparam int MAX_SIG_LEN_DEF = 16;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LONG     = 2'd3;

endpackage

### design/btsm_sp_ram.sv
// ----------------------------------------------------------------------------
// btsm_sp_ram
// single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
module btsm_sp_ram #(
  parameter int DEPTH = 256,
  parameter int DW    = 8
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [DW-1:0]            wdata,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### design/byte_trie_signature_matcher.sv
// ----------------------------------------------------------------------------
// byte_trie_signature_matcher
// byte-wise trie of file signatures in a node pool, insert and search walks
// ----------------------------------------------------------------------------
// usage:
//  - one byte per transfer: start high while busy is low moves command,
//    data_byte, last and sig_id into the block
//  - command insert walks and grows the trie, command search walks it only;
//    both kinds share one walk that starts at the root and ends on last
//  - a byte without last gives no result and busy drops again after
//    the child link read and the update/allocate step
//  - a byte with last steps through link read, node id read, id check and
//    write; result_strobe is high for one cycle right after, with found,
//    match_id, status and was_insert valid in that cycle
//  - the pace is set by the link memory: its read data picks the node that
//    the next byte reads from, so bytes cannot overlap
//  - the receiver cannot stall; a result is shown once and is gone after
//  - after reset the block sweeps both memories to zero, one entry a cycle,
//    over NODE_COUNT*256 link entries (65536 at the default size); busy stays high
//    for the whole sweep
// ----------------------------------------------------------------------------
module byte_trie_signature_matcher
  import btsm_pkg::*;
#(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int MAX_SIG_LEN = MAX_SIG_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                command,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic                last,
  input  logic [ID_W-1:0]     sig_id,
  output logic                result_strobe,
  output logic                found,
  output logic [ID_W-1:0]     match_id,
  output logic [STATUS_W-1:0] status,
  output logic                was_insert
);

  localparam int NW            = $clog2(NODE_COUNT);
  localparam int LINK_DEPTH    = NODE_COUNT * ALPHABET;
  localparam int LW            = $clog2(LINK_DEPTH);
  localparam int ALPHABET_BITS = $clog2(ALPHABET);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LINK  = 4'b0100,
    S_IDCHK = 4'b1000
  } state_t;

  state_t state;

  // clearing sweep address
  logic [LW-1:0] clear_addr;

  // walk state
  logic [NW-1:0]       walk_node, walk_node_next;
  logic                walk_stopped, walk_stopped_next;
  logic [DEPTH_W-1:0]  walk_depth, walk_depth_next;
  logic [STATUS_W-1:0] insert_error, insert_error_next;
  logic [NW:0]         next_free, next_free_next;

  // latched input transfer
  logic              cmd_q;
  logic [BYTE_W-1:0] byte_q;
  logic              last_q;
  logic [ID_W-1:0]   sig_q;

  // memory ports
  logic [LW-1:0]   link_addr;
  logic            link_we;
  logic [NW-1:0]   link_wdata, link_rdata;
  logic [NW-1:0]   id_addr;
  logic            id_we;
  logic [ID_W:0]   id_wdata, id_rdata;

  logic            accept;
  logic            link_zero, pool_full, too_deep;
  logic            node_has_id;
  logic [ID_W-1:0] node_id;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign link_zero   = (link_rdata == '0);
  assign pool_full   = (next_free >= (NW+1)'(NODE_COUNT));
  assign too_deep    = (walk_depth >= DEPTH_W'(MAX_SIG_LEN));
  assign node_has_id = id_rdata[ID_W];
  assign node_id     = id_rdata[ID_W-1:0];

  // child link memory: one entry per (node, byte), zero means no child
  btsm_sp_ram #(
    .DEPTH (LINK_DEPTH),
    .DW    (NW)
  ) u_link_ram (
    .clk   (clk),
    .addr  (link_addr),
    .we    (link_we),
    .wdata (link_wdata),
    .rdata (link_rdata)
  );

  // node id memory: {has id, id} per node
  btsm_sp_ram #(
    .DEPTH (NODE_COUNT),
    .DW    (ID_W + 1)
  ) u_id_ram (
    .clk   (clk),
    .addr  (id_addr),
    .we    (id_we),
    .wdata (id_wdata),
    .rdata (id_rdata)
  );

  // walk step on the link read data, applied in S_LINK
  always_comb begin
    walk_node_next    = walk_node;
    walk_stopped_next = walk_stopped;
    insert_error_next = insert_error;
    next_free_next    = next_free;
    walk_depth_next   = (walk_depth == DEPTH_SAT) ? walk_depth : walk_depth + 1'b1;
    if (cmd_q == CMD_INSERT) begin
      if (insert_error == ST_OK) begin
        if (too_deep) begin
          insert_error_next = ST_LONG;
        end else if (link_zero) begin
          if (pool_full) begin
            insert_error_next = ST_FULL;
          end else begin
            // allocate the next free node on the missing edge
            walk_node_next = next_free[NW-1:0];
            next_free_next = next_free + 1'b1;
          end
        end else begin
          walk_node_next = link_rdata;
        end
      end
    end else begin
      if (!walk_stopped && !too_deep) begin
        if (link_zero) begin
          walk_stopped_next = 1'b1;
        end else begin
          walk_node_next = link_rdata;
        end
      end
    end
  end

  // memory addressing: the link read is issued with the transfer itself
  always_comb begin
    link_addr  = {walk_node, byte_q};
    link_we    = 1'b0;
    link_wdata = next_free[NW-1:0];
    id_addr    = walk_node;
    id_we      = 1'b0;
    id_wdata   = {1'b1, sig_q};
    unique case (state)
      S_CLEAR: begin
        link_addr  = clear_addr;
        link_we    = 1'b1;
        link_wdata = '0;
        id_addr    = clear_addr[LW-1:ALPHABET_BITS];
        id_we      = 1'b1;
        id_wdata   = '0;
      end
      S_IDLE: begin
        link_addr = {walk_node, data_byte};
      end
      S_LINK: begin
        // write the new edge back at the entry just read
        link_we = (cmd_q == CMD_INSERT) && (insert_error == ST_OK) && !too_deep &&
                  link_zero && !pool_full;
        id_addr = walk_node_next;
      end
      S_IDCHK: begin
        id_we = (cmd_q == CMD_INSERT) && (insert_error == ST_OK) && !node_has_id;
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  // control and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clear_addr    <= '0;
      walk_node     <= '0;
      walk_stopped  <= 1'b0;
      walk_depth    <= '0;
      insert_error  <= ST_OK;
      next_free     <= (NW+1)'(1);
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == LW'(LINK_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_LINK;
          end
        end
        S_LINK: begin
          walk_node    <= walk_node_next;
          walk_stopped <= walk_stopped_next;
          walk_depth   <= walk_depth_next;
          insert_error <= insert_error_next;
          next_free    <= next_free_next;
          state        <= last_q ? S_IDCHK : S_IDLE;
        end
        S_IDCHK: begin
          // every final byte sends the walk back to the root
          walk_node     <= '0;
          walk_stopped  <= 1'b0;
          walk_depth    <= '0;
          insert_error  <= ST_OK;
          result_strobe <= 1'b1;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // input transfer and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= command;
      byte_q <= data_byte;
      last_q <= last;
      sig_q  <= sig_id;
    end
    if (state == S_IDCHK) begin
      if (cmd_q == CMD_SEARCH) begin
        found      <= node_has_id;
        match_id   <= node_has_id ? node_id : '0;
        status     <= ST_OK;
        was_insert <= 1'b0;
      end else begin
        found      <= 1'b0;
        match_id   <= '0;
        was_insert <= 1'b1;
        if (insert_error != ST_OK) begin
          status <= insert_error;
        end else if (node_has_id && (node_id != sig_q)) begin
          status <= ST_CONFLICT;
        end else begin
          status <= ST_OK;
        end
      end
    end
  end

  // a result only follows the id check
  a_strobe_after_check: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(state == S_IDCHK))
    else $error("result strobe without id check");

  // the pool never hands out more nodes than it holds
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= (NW+1)'(NODE_COUNT))
    else $error("next free node beyond pool");

  // the walk only stands on allocated nodes
  a_walk_allocated: assert property (@(posedge clk) disable iff (rst)
    (NW+1)'(walk_node) < next_free)
    else $error("walk on unallocated node");

  // the free pointer only moves when an edge is written
  a_alloc_writes_link: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK) && (next_free_next != next_free) |-> link_we)
    else $error("node allocated without link write");

  // the walk returns to the root with every result
  a_root_after_result: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> (walk_node == '0) && (walk_depth == '0) && !walk_stopped)
    else $error("walk not reset after result");

endmodule

### test/trie_result_checker.sv
// ----------------------------------------------------------------------------
// trie_result_checker
// watches the byte and result channels of the trie matcher, keeps its own
// copy of the trie and compares every result with the predicted one
// ----------------------------------------------------------------------------
module trie_result_checker
  import btsm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic                command,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic                last,
  input  logic [ID_W-1:0]     sig_id,
  input  logic                result_strobe,
  input  logic                found,
  input  logic [ID_W-1:0]     match_id,
  input  logic [STATUS_W-1:0] status,
  input  logic                was_insert,
  output int                  mismatches,
  output int                  pending,
  output int                  compared
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES   = NODE_COUNT_DEF;
  localparam int SIG_MAX = MAX_SIG_LEN_DEF;

  typedef struct packed {
    logic                found;
    logic [ID_W-1:0]     match_id;
    logic [STATUS_W-1:0] status;
    logic                was_insert;
  } trie_result_t;

  // trie copy: child pointer per node and byte, 0 means no child
  logic [7:0]          child_of [NODES*ALPHABET];
  logic                node_named [NODES];
  logic [ID_W-1:0]     node_tag [NODES];
  int                  free_node;

  // walk of the sequence in progress
  logic [7:0]          walk_at;
  logic                walk_halted;
  logic [DEPTH_W-1:0]  walk_len;
  logic [STATUS_W-1:0] walk_err;

  trie_result_t        awaited_results [$];
  trie_result_t        want;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic apply_trie_byte(input logic cmd, input logic [BYTE_W-1:0] b,
                                 input logic fin, input logic [ID_W-1:0] id);
    int           slot;
    trie_result_t res;
    slot = int'(walk_at) * ALPHABET + int'(b);
    if (cmd == CMD_INSERT) begin
      // first error of the sequence sticks, later insert bytes do nothing
      if (walk_err == ST_OK) begin
        if (walk_len >= SIG_MAX) begin
          walk_err = ST_LONG;
        end else begin
          if (child_of[slot] == '0) begin
            if (free_node >= NODES) begin
              walk_err = ST_FULL;
            end else begin
              child_of[slot] = 8'(free_node);
              free_node++;
            end
          end
          if (walk_err == ST_OK) walk_at = child_of[slot];
        end
      end
    end else if (!walk_halted && walk_len < SIG_MAX) begin
      if (child_of[slot] == '0) walk_halted = 1'b1;
      else walk_at = child_of[slot];
    end
    if (walk_len != DEPTH_SAT) walk_len++;

    if (fin) begin
      res = '0;
      if (cmd == CMD_SEARCH) begin
        res.found    = node_named[walk_at];
        res.match_id = node_named[walk_at] ? node_tag[walk_at] : '0;
        res.status   = ST_OK;
      end else begin
        res.was_insert = 1'b1;
        res.status     = walk_err;
        if (walk_err == ST_OK) begin
          if (!node_named[walk_at]) begin
            node_named[walk_at] = 1'b1;
            node_tag[walk_at]   = id;
          end else if (node_tag[walk_at] != id) begin
            res.status = ST_CONFLICT;
          end
        end
      end
      awaited_results.push_back(res);
      walk_at     = '0;
      walk_halted = 1'b0;
      walk_len    = '0;
      walk_err    = ST_OK;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NODES*ALPHABET; n++) child_of[n] = '0;
      for (int n = 0; n < NODES; n++) begin
        node_named[n] = 1'b0;
        node_tag[n]   = '0;
      end
      free_node   = 1;
      walk_at     = '0;
      walk_halted = 1'b0;
      walk_len    = '0;
      walk_err    = ST_OK;
      awaited_results.delete();
    end else begin
      // the result of this edge always belongs to an older byte, so check first
      if (result_strobe) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result (found %b id %0d status %0d insert %b) unexpected",
                                    found, match_id, status, was_insert));
        end else begin
          want = awaited_results.pop_front();
          compared++;
          if (found !== want.found)
            report_mismatch($sformatf("found got %b, expected %b", found, want.found));
          if (match_id !== want.match_id)
            report_mismatch($sformatf("match_id got %0d, expected %0d",
                                      match_id, want.match_id));
          if (status !== want.status)
            report_mismatch($sformatf("status got %0d, expected %0d", status, want.status));
          if (was_insert !== want.was_insert)
            report_mismatch($sformatf("was_insert got %b, expected %b",
                                      was_insert, want.was_insert));
        end
      end
      if (start && !busy) apply_trie_byte(command, data_byte, last, sig_id);
    end
    pending = awaited_results.size();
  end

endmodule

### test/byte_trie_signature_matcher_tb.sv
// ----------------------------------------------------------------------------
// byte_trie_signature_matcher_tb
// drives insert, search and mixed byte sequences into the trie matcher with
// bursty timing; a side checker predicts and compares every result
// ----------------------------------------------------------------------------
module byte_trie_signature_matcher_tb
  import btsm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIG_MAX     = MAX_SIG_LEN_DEF;
  localparam int BUF_LEN     = 48;
  // reset sweep of all link entries plus the traffic,
  // taken several times over
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {
    SEQ_NEW_SIG,
    SEQ_FILL_SIG,
    SEQ_LONG_SIG,
    SEQ_REINSERT,
    SEQ_FIND,
    SEQ_WINDOW,
    SEQ_LONG_WINDOW,
    SEQ_MIXED
  } seq_kind_t;

  // signature kept for later replay by searches and re-inserts
  typedef struct {
    logic [8*SIG_MAX-1:0] sig_bytes;
    int                   len;
    logic [ID_W-1:0]      id;
  } known_sig_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                command;
  logic [BYTE_W-1:0]   data_byte;
  logic                last;
  logic [ID_W-1:0]     sig_id;
  logic                result_strobe;
  logic                found;
  logic [ID_W-1:0]     match_id;
  logic [STATUS_W-1:0] status;
  logic                was_insert;

  int mismatches;
  int pending;
  int compared;
  int bytes_sent;
  int sequences_sent;
  int burst_left;
  int cycle_count;
  int kind_count [8];

  known_sig_t known_sigs [$];

  byte_trie_signature_matcher i_dut (
    .clk, .rst, .start, .busy, .command, .data_byte, .last, .sig_id,
    .result_strobe, .found, .match_id, .status, .was_insert
  );

  trie_result_checker i_checker (
    .clk, .rst, .start, .busy, .command, .data_byte, .last, .sig_id,
    .result_strobe, .found, .match_id, .status, .was_insert,
    .mismatches, .pending, .compared
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog, also catches results that never show up
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycle_count, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // bytes lean toward the low and high corners so that sequences share paths
  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 3));
      1:       return 8'($urandom_range(252, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // idle the sender, with junk on the fields while start is low
  task automatic pause_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      start     = 1'b0;
      command   = 1'($urandom_range(0, 1));
      data_byte = 8'($urandom_range(0, 255));
      last      = 1'($urandom_range(0, 1));
      sig_id    = ID_W'($urandom_range(0, 63));
    end
  endtask

  // one byte transfer: present at the falling edge, hold until busy is low
  // at a rising edge; start stays high into the next byte of a burst
  task automatic send_byte(input logic cmd, input logic [BYTE_W-1:0] b,
                           input logic fin, input logic [ID_W-1:0] id);
    if (burst_left == 0) begin
      pause_sender($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    command   = cmd;
    data_byte = b;
    last      = fin;
    sig_id    = id;
    start     = 1'b1;
    do @(posedge clk); while (busy);
    bytes_sent++;
  endtask

  // stop sending until every predicted result has come back
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic seq_kind_t pick_kind();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 28) return SEQ_NEW_SIG;
    if (roll < 43) return SEQ_REINSERT;
    if (roll < 68) return SEQ_FIND;
    if (roll < 78) return SEQ_WINDOW;
    if (roll < 90) return SEQ_MIXED;
    if (roll < 95) return SEQ_LONG_SIG;
    return SEQ_LONG_WINDOW;
  endfunction

  // build one sequence of the given kind and stream it out
  task automatic play_sequence(input seq_kind_t kind);
    logic [BYTE_W-1:0] seq_bytes [BUF_LEN];
    logic              seq_cmds  [BUF_LEN];
    int                len;
    logic [ID_W-1:0]   tag;
    logic              fill_cmd;
    bit                mixed;
    bit                have_prior;
    bit                copy_prior;
    known_sig_t        prior_sig;
    known_sig_t        fresh;

    have_prior = known_sigs.size() != 0;
    if (have_prior) prior_sig = known_sigs[$urandom_range(0, known_sigs.size() - 1)];
    // replays fall back to a fresh signature while nothing is stored yet
    if (!have_prior && (kind == SEQ_REINSERT || kind == SEQ_FIND)) kind = SEQ_NEW_SIG;
    tag      = ID_W'($urandom_range(0, 63));
    fill_cmd = CMD_INSERT;
    mixed    = 0;
    for (int i = 0; i < BUF_LEN; i++) seq_bytes[i] = rand_byte();
    copy_prior = have_prior && (kind == SEQ_REINSERT || kind == SEQ_FIND ||
                 kind == SEQ_LONG_WINDOW || (kind == SEQ_MIXED && $urandom_range(0, 1)));
    if (copy_prior)
      for (int i = 0; i < prior_sig.len; i++) seq_bytes[i] = prior_sig.sig_bytes[8*i +: 8];

    case (kind)
      SEQ_NEW_SIG:  len = $urandom_range(1, SIG_MAX);
      SEQ_FILL_SIG: begin
        // full-range bytes so that nearly every byte takes a new node
        len = SIG_MAX;
        for (int i = 0; i < SIG_MAX; i++) seq_bytes[i] = 8'($urandom_range(0, 255));
      end
      SEQ_LONG_SIG: len = $urandom_range(SIG_MAX + 1, SIG_MAX + 6);
      SEQ_REINSERT: begin
        // same id, another id, or only a prefix of the stored path
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, prior_sig.len) : prior_sig.len;
        if ($urandom_range(0, 1)) tag = prior_sig.id;
      end
      SEQ_FIND: begin
        fill_cmd = CMD_SEARCH;
        case ($urandom_range(0, 4))
          0:       len = $urandom_range(1, prior_sig.len);
          1:       len = prior_sig.len + $urandom_range(1, 8);
          default: len = prior_sig.len;
        endcase
      end
      SEQ_WINDOW: begin
        fill_cmd = CMD_SEARCH;
        len      = $urandom_range(1, SIG_MAX);
      end
      SEQ_LONG_WINDOW: begin
        // runs past the depth limit and can run past the walk depth saturation
        fill_cmd = CMD_SEARCH;
        len      = $urandom_range(SIG_MAX + 1, 40);
      end
      default: begin
        mixed = 1;
        len   = $urandom_range(1, 12);
      end
    endcase
    for (int i = 0; i < BUF_LEN; i++)
      seq_cmds[i] = mixed ? 1'($urandom_range(0, 1)) : fill_cmd;

    if ((kind == SEQ_NEW_SIG || kind == SEQ_FILL_SIG) && known_sigs.size() < 256) begin
      fresh.sig_bytes = '0;
      for (int i = 0; i < len; i++) fresh.sig_bytes[8*i +: 8] = seq_bytes[i];
      fresh.len = len;
      fresh.id  = tag;
      known_sigs.push_back(fresh);
    end

    for (int i = 0; i < len; i++)
      send_byte(seq_cmds[i], seq_bytes[i], i == len - 1,
                (i == len - 1) ? tag : ID_W'($urandom_range(0, 63)));
    kind_count[kind]++;
    sequences_sent++;
  endtask

  initial begin
    int target;
    rst       = 1'b1;
    start     = 1'b0;
    command   = CMD_INSERT;
    data_byte = '0;
    last      = 1'b0;
    sig_id    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed part ---
    // empty trie: the root holds no id, so a search finds nothing
    send_byte(CMD_SEARCH, 8'h00, 1'b1, 6'd63);
    // lowest byte with the lowest id, then found again
    send_byte(CMD_INSERT, 8'h00, 1'b1, 6'd0);
    send_byte(CMD_SEARCH, 8'h00, 1'b1, 6'd0);
    // highest byte and highest id, two levels deep
    send_byte(CMD_INSERT, 8'hFF, 1'b0, 6'd0);
    send_byte(CMD_INSERT, 8'hAA, 1'b1, 6'd63);
    // same id again is accepted
    send_byte(CMD_INSERT, 8'hFF, 1'b0, 6'd21);
    send_byte(CMD_INSERT, 8'hAA, 1'b1, 6'd63);
    // a different id on a named node is a conflict, old id stays
    send_byte(CMD_INSERT, 8'hFF, 1'b0, 6'd42);
    send_byte(CMD_INSERT, 8'hAA, 1'b1, 6'd21);
    // window falls off the trie, the bytes after the missing edge are ignored
    send_byte(CMD_SEARCH, 8'hFF, 1'b0, 6'd0);
    send_byte(CMD_SEARCH, 8'hAA, 1'b0, 6'd0);
    send_byte(CMD_SEARCH, 8'h55, 1'b0, 6'd0);
    send_byte(CMD_SEARCH, 8'hFF, 1'b1, 6'd0);
    // inner node without an id
    send_byte(CMD_SEARCH, 8'hFF, 1'b1, 6'd42);
    // insert and search bytes share one walk, last byte picks the kind
    send_byte(CMD_INSERT, 8'hFF, 1'b0, 6'd0);
    send_byte(CMD_SEARCH, 8'hAA, 1'b1, 6'd0);
    send_byte(CMD_SEARCH, 8'hFF, 1'b0, 6'd0);
    send_byte(CMD_INSERT, 8'h55, 1'b1, 6'd42);

    // --- random part ---
    // a full-length signature, an over-long one and an over-long window first
    play_sequence(SEQ_FILL_SIG);
    play_sequence(SEQ_LONG_SIG);
    play_sequence(SEQ_LONG_WINDOW);
    while (bytes_sent < 110) begin
      play_sequence(pick_kind());
      if ($urandom_range(0, 15) == 0) drain_results();
    end
    drain_results();

    // long fresh signatures until the node pool runs dry
    repeat (14) play_sequence(SEQ_FILL_SIG);

    // same mix again, now with the pool exhausted
    target = bytes_sent + 80;
    while (bytes_sent < target) begin
      play_sequence(pick_kind());
      if ($urandom_range(0, 15) == 0) drain_results();
    end

    drain_results();
    repeat (20) @(negedge clk);

    $display("run covered %0d bytes in %0d sequences: %0d fresh, %0d pool-fill, %0d over-long",
             bytes_sent, sequences_sent, kind_count[SEQ_NEW_SIG], kind_count[SEQ_FILL_SIG],
             kind_count[SEQ_LONG_SIG]);
    $display("%0d re-inserts, %0d searches, %0d mixed walks, %0d results compared",
             kind_count[SEQ_REINSERT],
             kind_count[SEQ_FIND] + kind_count[SEQ_WINDOW] + kind_count[SEQ_LONG_WINDOW],
             kind_count[SEQ_MIXED], compared);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
